FILE: hw/rtl/blps_pkg.sv
// shared constants and types for the boxcar leaky pulse shaper
`default_nettype none

package blps_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int WLEN_W     = 7;
  localparam int INV_W      = 17;
  localparam int DECAY_W    = 16;
  localparam int OUT_W      = 40;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR  = 2'd2;

  localparam logic [WLEN_W-1:0]  WLEN_RST  = 7'd1;
  localparam logic [INV_W-1:0]   INV_RST   = 17'd65536;
  localparam logic [DECAY_W-1:0] DECAY_RST = 16'd0;

  typedef struct packed {
    logic load;   // word accepted into the input stage
    logic pop;    // input stage moves to the result register
    logic clear;  // window length rewritten
  } win_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/blps_window.sv
// circular sample window with valid bits, read bypass and running sum
`default_nettype none

module blps_window import blps_pkg::*; #(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int LEN_W = $clog2(WINDOW_MAX + 1),
  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire win_ctrl_t              ctrl_i,
  input  wire logic [LEN_W-1:0]       len_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic      [SUM_W-1:0]       sum_o
);

  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] mem_rd_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [SAMPLE_BITS-1:0] byp_val_q;
  logic [SAMPLE_BITS-1:0] old_smp;
  logic [SLOT_W-1:0]      slot_q;
  logic [SLOT_W-1:0]      wr_slot_q;
  logic [SLOT_W-1:0]      cur_slot;
  logic [SLOT_W-1:0]      nxt_slot;
  logic [WINDOW_MAX-1:0]  vld_q;
  logic                   byp_q;
  logic                   hit_q;
  logic [SUM_W-1:0]       sum_q;

  always_comb begin
    cur_slot = (LEN_W'(slot_q) >= len_i) ? '0 : slot_q;
    nxt_slot = ((LEN_W'(cur_slot) + LEN_W'(1)) >= len_i) ? '0 : cur_slot + SLOT_W'(1);
  end

  // slot leaving the window: just written by the word ahead, never written, or from memory
  assign old_smp = byp_q ? byp_val_q : (hit_q ? mem_rd_q : '0);
  assign sum_o   = sum_q - SUM_W'(old_smp) + SUM_W'(smp_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pop) begin
      mem[wr_slot_q] <= smp_q;
    end
    if (ctrl_i.load) begin
      mem_rd_q  <= mem[cur_slot];
      smp_q     <= sample_i;
      wr_slot_q <= cur_slot;
      byp_val_q <= smp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      sum_q  <= '0;
      vld_q  <= '0;
      byp_q  <= 1'b0;
      hit_q  <= 1'b0;
    end else if (ctrl_i.clear) begin
      slot_q <= '0;
      sum_q  <= '0;
      vld_q  <= '0;
    end else begin
      if (ctrl_i.load) begin
        slot_q <= nxt_slot;
        byp_q  <= ctrl_i.pop && (wr_slot_q == cur_slot);
        hit_q  <= vld_q[cur_slot];
      end
      if (ctrl_i.pop) begin
        sum_q            <= sum_o;
        vld_q[wr_slot_q] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/blps_shaper.sv
// leaky integrator: decayed previous output plus window mean, saturating
`default_nettype none

module blps_shaper import blps_pkg::*; #(
  parameter int SUM_W = 22
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               pop_i,
  input  wire logic [SUM_W-1:0]   sum_i,
  input  wire logic [INV_W-1:0]   inv_i,
  input  wire logic [DECAY_W-1:0] decay_i,
  output logic      [OUT_W-1:0]   shaped_o
);

  localparam int MEAN_W = SUM_W + INV_W;
  localparam int TOT_W  = ((MEAN_W > OUT_W) ? MEAN_W : OUT_W) + 1;

  logic [OUT_W+DECAY_W-1:0] prod;
  logic [OUT_W-1:0]         decayed;
  logic [MEAN_W-1:0]        mean;
  logic [TOT_W-1:0]         total;
  logic [OUT_W-1:0]         last_d;
  logic [OUT_W-1:0]         last_q;

  always_comb begin
    prod    = (OUT_W + DECAY_W)'(last_q) * (OUT_W + DECAY_W)'(decay_i);
    decayed = prod[OUT_W+DECAY_W-1:DECAY_W];
    mean    = MEAN_W'(sum_i) * MEAN_W'(inv_i);
    total   = TOT_W'(decayed) + TOT_W'(mean);
    last_d  = (total > TOT_W'(OUT_MAX)) ? OUT_MAX : total[OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (pop_i) begin
      last_q <= last_d;
    end
  end

  assign shaped_o = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/boxcar_leaky_pulse_shaper.sv
// Boxcar-plus-leaky-integrator pulse shaper. Takes one sample word per clock while the output
// is not stalled, and presents one shaped word per sample through the input stage and then the
// result register. The rate of one word per cycle is kept by the window memory read with write
// bypass and by the feedback of the previous output through the decay multiply; out_ready_i low
// with a full result register holds the flow.
// shaped = floor(prev * decay_factor / 2^16) + window_sum * inv_window, saturating at 2^40-1.
// Writing window_length empties the window (the previous output is kept); inv_window must be
// kept consistent with it by software. Configure only while idle.
`default_nettype none

module boxcar_leaky_pulse_shaper import blps_pkg::*; #(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [OUT_W-1:0]       shaped_o
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);

  logic [WLEN_W-1:0]  wlen_q;
  logic [INV_W-1:0]   inv_q;
  logic [DECAY_W-1:0] decay_q;
  logic [LEN_W-1:0]   len;
  logic               a_valid_q;
  logic               out_valid_q;
  logic               pop;
  logic               load;
  win_ctrl_t          wctrl;
  logic [SUM_W-1:0]   sum_next;

  always_comb begin
    priority if (wlen_q == '0) begin
      len = LEN_W'(1);
    end else if (32'(wlen_q) > 32'(WINDOW_MAX)) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = LEN_W'(wlen_q);
    end
  end

  assign pop         = a_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !a_valid_q || pop;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign wctrl.load  = load;
  assign wctrl.pop   = pop;
  assign wctrl.clear = cfg_we_i && (cfg_index_i == CFG_WINDOW_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q      <= WLEN_RST;
      inv_q       <= INV_RST;
      decay_q     <= DECAY_RST;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_WINDOW_LENGTH: wlen_q  <= cfg_data_i[WLEN_W-1:0];
          CFG_INV_WINDOW:    inv_q   <= cfg_data_i[INV_W-1:0];
          CFG_DECAY_FACTOR:  decay_q <= cfg_data_i[DECAY_W-1:0];
          default: ;
        endcase
      end
      if (load) begin
        a_valid_q <= 1'b1;
      end else if (pop) begin
        a_valid_q <= 1'b0;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  blps_window #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (wctrl),
    .len_i    (len),
    .sample_i (sample_i),
    .sum_o    (sum_next)
  );

  blps_shaper #(
    .SUM_W (SUM_W)
  ) u_shaper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pop_i    (pop),
    .sum_i    (sum_next),
    .inv_i    (inv_q),
    .decay_i  (decay_q),
    .shaped_o (shaped_o)
  );

  // a new result only ever comes from a word sitting in the input stage
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(a_valid_q))
    else $error("result appeared without a word in the input stage");

  // a word in the input stage with a free result register moves on
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !out_valid_q |=> out_valid_q)
    else $error("input stage did not advance into empty result register");

  // full pipe with a stalled output must not take another word
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while pipeline full and stalled");

endmodule

`default_nettype wire
